>>> sv/tmcg_pkg.sv
// Shared types, sizes and operation codes of the text-mode character generator.
// No dependencies; imported by the interfaces, the cursor unit and the top level.
package tmcg_pkg;

  // Screen geometry
  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int GLYPH_ROWS  = 12;
  localparam int GLYPH_WIDTH = 8;
  localparam int GLYPH_DEPTH = 3072;
  localparam int CELL_DEPTH  = COLUMNS * ROWS;
  localparam int PIX_WIDTH   = COLUMNS * GLYPH_WIDTH;
  localparam int PIX_HEIGHT  = ROWS * GLYPH_ROWS;

  localparam int CELL_AW  = 11;
  localparam int GLYPH_AW = 12;
  localparam int CELL_DW  = 24;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int BLINK_W  = 6;
  localparam int CFG_IDX_W = 1;

  // Reset values of the blink reload registers
  localparam logic [BLINK_W-1:0] BLINK_ON_RESET  = 6'd45;
  localparam logic [BLINK_W-1:0] BLINK_OFF_RESET = 6'd15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_OFF = 1'b1;

  typedef enum logic [2:0] {
    MODE_CELL_WR     = 3'd0,
    MODE_GLYPH_WR    = 3'd1,
    MODE_BLINK_TICK  = 3'd2,
    MODE_PIXEL       = 3'd3,
    MODE_CURSOR_MOVE = 3'd4,
    MODE_CURSOR_EN   = 3'd5
  } mode_t;

  // Item in the last pipeline stage, handed to the cursor unit
  typedef struct packed {
    logic [2:0]        mode;
    logic [2:0]        px_bit;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              err;
    logic [7:0]        bg;
    logic [7:0]        fg;
    logic signed [7:0] cur_col;
    logic signed [5:0] cur_row;
    logic              cur_en;
  } stage_c_t;

  typedef struct packed {
    logic [7:0] pixel_color;
    logic       blink_toggled;
    logic       enable_changed;
    logic       coord_error;
  } result_t;

endpackage

>>> sv/tmcg_if.sv
// Channel interfaces of the character generator: input items, results, config writes.
// Depends on tmcg_pkg for field widths.
interface tmcg_in_if;
  import tmcg_pkg::*;
  logic                valid;
  logic                ready;
  logic [2:0]          mode;
  logic [CELL_AW-1:0]  cell_index;
  logic [7:0]          char_code;
  logic [7:0]          bg_color;
  logic [7:0]          fg_color;
  logic [GLYPH_AW-1:0] glyph_index;
  logic [7:0]          glyph_byte;
  logic [9:0]          pixel_x;
  logic [8:0]          pixel_y;
  logic signed [7:0]   cursor_col;
  logic signed [5:0]   cursor_row;
  logic                cursor_enable;

  modport source (output valid, mode, cell_index, char_code, bg_color, fg_color,
                  glyph_index, glyph_byte, pixel_x, pixel_y, cursor_col, cursor_row,
                  cursor_enable, input ready);
  modport sink (input valid, mode, cell_index, char_code, bg_color, fg_color,
                glyph_index, glyph_byte, pixel_x, pixel_y, cursor_col, cursor_row,
                cursor_enable, output ready);
endinterface

interface tmcg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_color;
  logic       blink_toggled;
  logic       enable_changed;
  logic       coord_error;

  modport source (output valid, pixel_color, blink_toggled, enable_changed, coord_error,
                  input ready);
  modport sink (input valid, pixel_color, blink_toggled, enable_changed, coord_error,
                output ready);
endinterface

interface tmcg_cfg_if;
  import tmcg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BLINK_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/tmcg_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No package dependency; used for the cell store and the glyph store.
module tmcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds while en is low, so a stalled pipeline keeps its operand
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else if (re) begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> sv/tmcg_cursor.sv
// Cursor and blink state, blink reload registers and final color selection.
// Depends on tmcg_pkg (stage_c_t, result_t, mode codes).
module tmcg_cursor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  tmcg_pkg::stage_c_t            req,
  input  logic [7:0]                    glyph_bits,
  input  logic                          cfg_we,
  input  logic [tmcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tmcg_pkg::BLINK_W-1:0]  cfg_data,
  output tmcg_pkg::result_t             res
);
  import tmcg_pkg::*;

  logic [COL_W-1:0]   cursor_col_r, cursor_col_nxt;
  logic [ROW_W-1:0]   cursor_row_r, cursor_row_nxt;
  logic               enabled_r, enabled_nxt;
  logic               visible_r, visible_nxt;
  logic [BLINK_W-1:0] blink_cnt_r, blink_cnt_nxt;
  logic [BLINK_W-1:0] blink_on_r, blink_off_r;

  logic               blink_fire;
  logic [BLINK_W-1:0] cnt_dec;
  logic [7:0]         move_col;
  logic [5:0]         move_row;
  logic               swap;
  logic               pix_bit;

  always_comb begin
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    enabled_nxt    = enabled_r;
    visible_nxt    = visible_r;
    blink_cnt_nxt  = blink_cnt_r;
    blink_fire     = 1'b0;
    res            = '0;

    cnt_dec  = (blink_cnt_r != '0) ? blink_cnt_r - 1'b1 : '0;
    move_col = req.cur_col[7] ? {1'b0, cursor_col_r} : req.cur_col;
    move_row = req.cur_row[5] ? {1'b0, cursor_row_r} : req.cur_row;
    swap     = enabled_r && visible_r && (req.row == cursor_row_r) &&
               (req.col == cursor_col_r);
    pix_bit  = glyph_bits[3'd7 - req.px_bit];

    case (req.mode)
      MODE_BLINK_TICK: begin
        if (enabled_r) begin
          blink_cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            blink_fire        = fire;
            visible_nxt       = !visible_r;
            blink_cnt_nxt     = visible_r ? blink_off_r : blink_on_r;
            res.blink_toggled = 1'b1;
          end
        end
      end
      MODE_PIXEL: begin
        if (req.err) begin
          res.coord_error = 1'b1;
        end else if (pix_bit) begin
          res.pixel_color = swap ? req.bg : req.fg;
        end else begin
          res.pixel_color = swap ? req.fg : req.bg;
        end
      end
      MODE_CURSOR_MOVE: begin
        if ((int'(move_col) < COLUMNS) && (int'(move_row) < ROWS)) begin
          cursor_col_nxt = move_col[COL_W-1:0];
          cursor_row_nxt = move_row[ROW_W-1:0];
        end
      end
      MODE_CURSOR_EN: begin
        res.enable_changed = (req.cur_en != enabled_r);
        enabled_nxt        = req.cur_en;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      enabled_r    <= 1'b1;
      visible_r    <= 1'b1;
      blink_cnt_r  <= '0;
    end else if (fire) begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      enabled_r    <= enabled_nxt;
      visible_r    <= visible_nxt;
      blink_cnt_r  <= blink_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_on_r  <= BLINK_ON_RESET;
      blink_off_r <= BLINK_OFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLINK_ON:  blink_on_r  <= cfg_data;
        CFG_BLINK_OFF: blink_off_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cursor_col_r) < COLUMNS) else $error("cursor column off screen");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cursor_row_r) < ROWS) else $error("cursor row off screen");

  a_vis_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (visible_r != $past(visible_r))) |-> $past(blink_fire))
    else $error("cursor visibility changed without a blink toggle");

endmodule

>>> sv/text_mode_character_generator.sv
// Top level of the text-mode character generator: three-stage pipeline around
// the cell RAM and glyph RAM. Depends on tmcg_pkg, tmcg_if, tmcg_ram, tmcg_cursor.
//
// Usage:
//   in_chan   carries one operation per transaction, selected by mode: cell write,
//             glyph write, blink tick, pixel request, cursor move, cursor enable.
//   out_chan  returns exactly one result transaction for every input transaction,
//             in order: pixel color, blink toggle flag, enable-changed flag and
//             off-screen flag (fields that do not apply read 0).
//   cfg_chan  writes the blink reload registers (index 0 visible ticks, index 1
//             hidden ticks); always ready, write only while the block is idle.
// Timing: one item per cycle sustained while results are taken; an accepted item is
//   registered into stage B, then stage C, then the output register. Stage A
//   (the accepting cycle) reads the cell RAM, stage B reads the glyph RAM with the
//   character found, stage C applies the cursor and blink logic and loads the
//   output register.
// Each store and the cursor state is touched in one stage only, and items flow in
//   order, so no forwarding or interlock is needed.
// Stall: while a result waits on out_chan the whole pipeline holds, RAM read data
//   included, and in_chan.ready drops; a taken result frees a slot the same cycle.
// Reset: rst_n (synchronous, active low) empties the pipeline, puts the cursor at
//   column 0 row 0, enabled and visible, blink count 0, reloads 45 and 15. The
//   stores hold nothing defined until written.
module text_mode_character_generator (
  input logic         clk,
  input logic         rst_n,
  tmcg_in_if.sink     in_chan,
  tmcg_out_if.source  out_chan,
  tmcg_cfg_if.sink    cfg_chan
);
  import tmcg_pkg::*;

  // Reciprocal for the division of a pixel row by the glyph height
  localparam int DIV12_MUL   = 683;
  localparam int DIV12_SHIFT = 13;

  logic advance;
  logic in_acc;

  // Stage A: decode and cell RAM access
  logic                px_err;
  logic [18:0]         div_prod;
  logic [5:0]          quot;
  logic [CELL_AW-1:0]  pix_addr;
  logic [CELL_AW-1:0]  cell_addr;
  logic                cell_we;
  logic                cell_re;
  logic [CELL_DW-1:0]  cell_rdata;

  // Stage B registers
  logic                s1_valid_r;
  logic [2:0]          s1_mode_r;
  logic [2:0]          s1_px_bit_r;
  logic [8:0]          s1_py_r;
  logic [5:0]          s1_quot_r;
  logic [COL_W-1:0]    s1_col_r;
  logic                s1_err_r;
  logic [GLYPH_AW-1:0] s1_gidx_r;
  logic [7:0]          s1_gbyte_r;
  logic signed [7:0]   s1_cur_col_r;
  logic signed [5:0]   s1_cur_row_r;
  logic                s1_cur_en_r;

  logic [8:0]          glyph_rem;
  logic [GLYPH_AW-1:0] pix_gaddr;
  logic [GLYPH_AW-1:0] glyph_addr;
  logic                glyph_we;
  logic                glyph_re;
  logic [7:0]          glyph_rdata;

  // Stage C registers
  logic                s2_valid_r;
  stage_c_t            s2_r;
  result_t             res;

  // Output register
  logic                out_valid_r;
  result_t             out_r;

  assign advance       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = advance;
  assign in_acc        = in_chan.valid && advance;
  assign cfg_chan.ready = 1'b1;

  // ---- Stage A ----
  always_comb begin
    px_err   = (int'(in_chan.pixel_x) >= PIX_WIDTH) || (int'(in_chan.pixel_y) >= PIX_HEIGHT);
    div_prod = 19'(int'(in_chan.pixel_y) * DIV12_MUL);
    quot     = div_prod[18:DIV12_SHIFT];
    pix_addr = CELL_AW'(int'(quot[ROW_W-1:0]) * COLUMNS +
                        int'(in_chan.pixel_x[9:3]));
    cell_addr = (in_chan.mode == MODE_CELL_WR) ? in_chan.cell_index : pix_addr;
    cell_we   = in_acc && (in_chan.mode == MODE_CELL_WR) &&
                (int'(in_chan.cell_index) < CELL_DEPTH);
    cell_re   = in_acc && (in_chan.mode == MODE_PIXEL) && !px_err;
  end

  // Cell word layout: character, background, foreground
  tmcg_ram #(.WIDTH(CELL_DW), .DEPTH(CELL_DEPTH)) u_cell_ram (
    .clk   (clk),
    .en    (advance),
    .we    (cell_we),
    .re    (cell_re),
    .addr  (cell_addr),
    .wdata ({in_chan.char_code, in_chan.bg_color, in_chan.fg_color}),
    .rdata (cell_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mode_r    <= in_chan.mode;
      s1_px_bit_r  <= in_chan.pixel_x[2:0];
      s1_py_r      <= in_chan.pixel_y;
      s1_quot_r    <= quot;
      s1_col_r     <= in_chan.pixel_x[9:3];
      s1_err_r     <= px_err;
      s1_gidx_r    <= in_chan.glyph_index;
      s1_gbyte_r   <= in_chan.glyph_byte;
      s1_cur_col_r <= in_chan.cursor_col;
      s1_cur_row_r <= in_chan.cursor_row;
      s1_cur_en_r  <= in_chan.cursor_enable;
    end
  end

  // ---- Stage B: glyph row is the pixel row modulo the glyph height ----
  always_comb begin
    glyph_rem  = s1_py_r - 9'(int'(s1_quot_r) * GLYPH_ROWS);
    pix_gaddr  = GLYPH_AW'(int'(cell_rdata[23:16]) * GLYPH_ROWS + int'(glyph_rem[3:0]));
    glyph_addr = (s1_mode_r == MODE_GLYPH_WR) ? s1_gidx_r : pix_gaddr;
    glyph_we   = advance && s1_valid_r && (s1_mode_r == MODE_GLYPH_WR) &&
                 (int'(s1_gidx_r) < GLYPH_DEPTH);
    glyph_re   = advance && s1_valid_r && (s1_mode_r == MODE_PIXEL) && !s1_err_r;
  end

  tmcg_ram #(.WIDTH(8), .DEPTH(GLYPH_DEPTH)) u_glyph_ram (
    .clk   (clk),
    .en    (advance),
    .we    (glyph_we),
    .re    (glyph_re),
    .addr  (glyph_addr),
    .wdata (s1_gbyte_r),
    .rdata (glyph_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_r.mode    <= s1_mode_r;
      s2_r.px_bit  <= s1_px_bit_r;
      s2_r.row     <= s1_quot_r[ROW_W-1:0];
      s2_r.col     <= s1_col_r;
      s2_r.err     <= s1_err_r;
      s2_r.bg      <= cell_rdata[15:8];
      s2_r.fg      <= cell_rdata[7:0];
      s2_r.cur_col <= s1_cur_col_r;
      s2_r.cur_row <= s1_cur_row_r;
      s2_r.cur_en  <= s1_cur_en_r;
    end
  end

  // ---- Stage C: cursor, blink and color choice ----
  tmcg_cursor u_cursor (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (advance && s2_valid_r),
    .req        (s2_r),
    .glyph_bits (glyph_rdata),
    .cfg_we     (cfg_chan.valid),
    .cfg_index  (cfg_chan.index),
    .cfg_data   (cfg_chan.data),
    .res        (res)
  );

  // Hold the result until taken; load the next one when the slot frees
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.pixel_color    = out_r.pixel_color;
  assign out_chan.blink_toggled  = out_r.blink_toggled;
  assign out_chan.enable_changed = out_r.enable_changed;
  assign out_chan.coord_error    = out_r.coord_error;

  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance) |=> s2_valid_r)
    else $error("item lost between glyph stage and cursor stage");

  a_err_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.coord_error) |-> (out_r.pixel_color == 8'd0))
    else $error("off-screen pixel with nonzero color");

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_r.blink_toggled, out_r.enable_changed, out_r.coord_error}))
    else $error("more than one result flag set");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> (s2_valid_r == $past(s2_valid_r)))
    else $error("pipeline moved during a stall");

endmodule
